[rtl/dual_channel_frame_peak_stats_core_defines.svh]
// Assertion macros for the dual-channel frame peak statistics core.
`ifndef DUAL_CHANNEL_FRAME_PEAK_STATS_CORE_DEFINES_SVH
`define DUAL_CHANNEL_FRAME_PEAK_STATS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DCFPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define DCFPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DCFPS_ASSERT_NEXT(label, ante, cons, msg)
`define DCFPS_ASSERT_NOW(label, ante, cons, msg)
`endif

`endif

[rtl/dcfps_pkg.sv]
// Shared constants and types for the dual-channel frame peak statistics core.
package dcfps_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int WEIGHT_BITS     = 9;
    localparam int FRAC_BITS       = 8;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = 9'd256;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 9'd128;

    typedef struct packed {
        logic take;
        logic last;
        logic fire;
    } lane_ctl_t;

endpackage

[rtl/dcfps_if.sv]
// Stream and configuration interfaces of the dual-channel frame peak statistics core.
interface dcfps_in_if #(parameter int SAMPLE_BITS = dcfps_pkg::SAMPLE_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic                   frame_end;

    modport source (output valid, output sample_a, output sample_b, output frame_end,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input frame_end,
                    output ready);
endinterface

interface dcfps_out_if #(parameter int SAMPLE_BITS = dcfps_pkg::SAMPLE_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] swing_a;
    logic [SAMPLE_BITS-1:0] swing_b;
    logic [SAMPLE_BITS-1:0] midpoint_a;
    logic [SAMPLE_BITS-1:0] midpoint_b;

    modport source (output valid, output swing_a, output swing_b, output midpoint_a,
                    output midpoint_b, input ready);
    modport sink   (input valid, input swing_a, input swing_b, input midpoint_a,
                    input midpoint_b, output ready);
endinterface

interface dcfps_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dcfps_pkg::WEIGHT_BITS-1:0]  filter_weight;

    modport source (output valid, output filter_weight, input ready);
    modport sink   (input valid, input filter_weight, output ready);
endinterface

[rtl/dcfps_tracker.sv]
// Per-channel running max/min tracker with frame-end capture register.
module dcfps_tracker #(
    parameter int SAMPLE_BITS = dcfps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dcfps_pkg::lane_ctl_t   ctl,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [SAMPLE_BITS-1:0] frame_hi,
    output logic [SAMPLE_BITS-1:0] frame_lo
);

    logic [SAMPLE_BITS-1:0] hi_reg;
    logic [SAMPLE_BITS-1:0] lo_reg;
    logic [SAMPLE_BITS-1:0] hi_next;
    logic [SAMPLE_BITS-1:0] lo_next;
    logic [SAMPLE_BITS-1:0] frame_hi_reg;
    logic [SAMPLE_BITS-1:0] frame_lo_reg;

    always_comb
    begin
        hi_next = (sample > hi_reg) ? sample : hi_reg;
        lo_next = (sample < lo_reg) ? sample : lo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg <= '0;
            lo_reg <= '1;
        end
        else if (ctl.take)
        begin
            if (ctl.last)
            begin
                hi_reg <= '0;
                lo_reg <= '1;
            end
            else
            begin
                hi_reg <= hi_next;
                lo_reg <= lo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take && ctl.last)
        begin
            frame_hi_reg <= hi_next;
            frame_lo_reg <= lo_next;
        end
    end

    assign frame_hi = frame_hi_reg;
    assign frame_lo = frame_lo_reg;

endmodule

[rtl/dcfps_smoother.sv]
// Per-channel swing low-pass filter and midrange computation.
module dcfps_smoother #(
    parameter int SAMPLE_BITS = dcfps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dcfps_pkg::lane_ctl_t              ctl,
    input  logic [dcfps_pkg::WEIGHT_BITS-1:0] weight,
    input  logic [SAMPLE_BITS-1:0]            frame_hi,
    input  logic [SAMPLE_BITS-1:0]            frame_lo,
    output logic [SAMPLE_BITS-1:0]            swing,
    output logic [SAMPLE_BITS-1:0]            midpoint
);

    localparam int AccBits = SAMPLE_BITS + dcfps_pkg::WEIGHT_BITS;

    logic [SAMPLE_BITS-1:0]            smooth_reg;
    logic [SAMPLE_BITS-1:0]            raw;
    logic [dcfps_pkg::WEIGHT_BITS-1:0] weight_inv;
    logic [AccBits-1:0]                acc;
    logic [SAMPLE_BITS:0]              mid_sum;

    always_comb
    begin
        raw        = (frame_hi >= frame_lo) ? (frame_hi - frame_lo) : '0;
        weight_inv = dcfps_pkg::WEIGHT_ONE - weight;
        acc        = AccBits'(weight) * AccBits'(raw)
                   + AccBits'(weight_inv) * AccBits'(smooth_reg);
        swing      = acc[dcfps_pkg::FRAC_BITS +: SAMPLE_BITS];
        mid_sum    = {1'b0, frame_hi} + {1'b0, frame_lo};
        midpoint   = mid_sum[SAMPLE_BITS:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
        end
        else if (ctl.fire)
        begin
            smooth_reg <= swing;
        end
    end

endmodule

[rtl/dual_channel_frame_peak_stats_core.sv]
// Top level of the dual-channel frame peak statistics core.
// Takes one sample-pair word per clock. Each channel has its own tracker and
// smoother lane; a frame-end word is captured into the frame register at the
// edge that accepts it, and both lanes' filtered swing and midrange are then
// merged into the output register once that register is empty or being read.
// Input words keep flowing at one per cycle unless a result waits in the
// output register while another frame result is also pending. Weight writes
// above 256 act as 256.
`include "dual_channel_frame_peak_stats_core_defines.svh"

module dual_channel_frame_peak_stats_core #(
    parameter int SAMPLE_BITS = dcfps_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dcfps_in_if.sink      in,
    dcfps_out_if.source   out,
    dcfps_cfg_if.sink     cfg
);

    logic [dcfps_pkg::WEIGHT_BITS-1:0] weight_reg;
    logic [dcfps_pkg::WEIGHT_BITS-1:0] weight_sat;
    logic                              frame_valid_reg;
    logic                              out_valid_reg;
    logic [SAMPLE_BITS-1:0]            swing_a_reg;
    logic [SAMPLE_BITS-1:0]            swing_b_reg;
    logic [SAMPLE_BITS-1:0]            mid_a_reg;
    logic [SAMPLE_BITS-1:0]            mid_b_reg;
    dcfps_pkg::lane_ctl_t              ctl;
    logic [SAMPLE_BITS-1:0]            hi_a;
    logic [SAMPLE_BITS-1:0]            lo_a;
    logic [SAMPLE_BITS-1:0]            hi_b;
    logic [SAMPLE_BITS-1:0]            lo_b;
    logic [SAMPLE_BITS-1:0]            swing_a;
    logic [SAMPLE_BITS-1:0]            swing_b;
    logic [SAMPLE_BITS-1:0]            mid_a;
    logic [SAMPLE_BITS-1:0]            mid_b;

    always_comb
    begin
        ctl.fire   = frame_valid_reg && (!out_valid_reg || out.ready);
        in.ready   = !frame_valid_reg || ctl.fire;
        ctl.take   = in.valid && in.ready;
        ctl.last   = in.frame_end;
        cfg.ready  = 1'b1;
        weight_sat = (weight_reg > dcfps_pkg::WEIGHT_ONE) ? dcfps_pkg::WEIGHT_ONE
                                                          : weight_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= dcfps_pkg::WEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            weight_reg <= cfg.filter_weight;
        end
    end

    dcfps_tracker #(.SAMPLE_BITS(SAMPLE_BITS)) u_track_a (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(in.sample_a),
        .frame_hi(hi_a), .frame_lo(lo_a)
    );

    dcfps_tracker #(.SAMPLE_BITS(SAMPLE_BITS)) u_track_b (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(in.sample_b),
        .frame_hi(hi_b), .frame_lo(lo_b)
    );

    dcfps_smoother #(.SAMPLE_BITS(SAMPLE_BITS)) u_smooth_a (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .weight(weight_sat),
        .frame_hi(hi_a), .frame_lo(lo_a), .swing(swing_a), .midpoint(mid_a)
    );

    dcfps_smoother #(.SAMPLE_BITS(SAMPLE_BITS)) u_smooth_b (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .weight(weight_sat),
        .frame_hi(hi_b), .frame_lo(lo_b), .swing(swing_b), .midpoint(mid_b)
    );

    // frame register and output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.take && ctl.last)
            begin
                frame_valid_reg <= 1'b1;
            end
            else if (ctl.fire)
            begin
                frame_valid_reg <= 1'b0;
            end

            if (ctl.fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // merge lanes into the output word
    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            swing_a_reg <= swing_a;
            swing_b_reg <= swing_b;
            mid_a_reg   <= mid_a;
            mid_b_reg   <= mid_b;
        end
    end

    assign out.valid      = out_valid_reg;
    assign out.swing_a    = swing_a_reg;
    assign out.swing_b    = swing_b_reg;
    assign out.midpoint_a = mid_a_reg;
    assign out.midpoint_b = mid_b_reg;

    `DCFPS_ASSERT_NEXT(a_frame_held, frame_valid_reg && !ctl.fire, frame_valid_reg, "frame result dropped")
    `DCFPS_ASSERT_NEXT(a_frame_loaded, ctl.take && ctl.last, frame_valid_reg, "frame end not captured")
    `DCFPS_ASSERT_NEXT(a_fire_out, ctl.fire, out_valid_reg, "merged word not presented")
    `DCFPS_ASSERT_NOW(a_no_overwrite, ctl.fire, !out_valid_reg || out.ready, "output word overwritten")

endmodule

[sim/tb_dual_channel_frame_peak_stats_core.sv]
// Self-checking testbench for the dual-channel frame peak statistics core.
module tb_dual_channel_frame_peak_stats_core;

    localparam int SB           = dcfps_pkg::SAMPLE_BITS_DEF;
    localparam int FULL_SCALE   = (1 << SB) - 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PAIRS_PER_PHASE = 115;

    typedef struct packed {
        logic [SB-1:0] sample_a;
        logic [SB-1:0] sample_b;
        logic          frame_end;
    } pair_word_t;

    typedef struct packed {
        logic [SB-1:0] swing_a;
        logic [SB-1:0] swing_b;
        logic [SB-1:0] midpoint_a;
        logic [SB-1:0] midpoint_b;
    } frame_stats_t;

    typedef enum {SPREAD_FULL, SPREAD_EDGES, SPREAD_BAND} spread_t;

    logic clk;
    logic rst_n;

    dcfps_in_if  #(.SAMPLE_BITS(SB)) pair_bus ();
    dcfps_out_if #(.SAMPLE_BITS(SB)) stats_bus ();
    dcfps_cfg_if                     weight_bus ();

    dual_channel_frame_peak_stats_core #(.SAMPLE_BITS(SB)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (pair_bus),
        .out   (stats_bus),
        .cfg   (weight_bus)
    );

    pair_word_t   pair_queue [$];
    frame_stats_t stats_due [$];

    logic [SB-1:0]                     peak_hi [2];
    logic [SB-1:0]                     peak_lo [2];
    logic [SB-1:0]                     smooth  [2];
    logic [dcfps_pkg::WEIGHT_BITS-1:0] model_weight;

    int errors = 0;
    int pairs_sent = 0;
    int frames_checked = 0;
    int weight_writes = 0;
    int cycle_count = 0;

    int gap_left = 0;
    int burst_left = 0;
    int hold_left = 0;
    int run_left = 0;
    bit sender_steady = 0;
    bit receiver_steady = 0;
    pair_word_t next_pair;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [SB-1:0] got,
                               input logic [SB-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("frame %0d %s got %0d expected %0d",
                                      frames_checked, name, got, want));
    endtask

    // Tracks one accepted word; on frame end computes the filtered swing and midrange.
    task automatic track_pair(input pair_word_t w);
        logic [SB-1:0] s [2];
        int unsigned   eff_w;
        int unsigned   raw;
        int unsigned   acc;
        logic [SB-1:0] mid [2];
        s[0] = w.sample_a;
        s[1] = w.sample_b;
        for (int ch = 0; ch < 2; ch++)
        begin
            if (s[ch] > peak_hi[ch])
                peak_hi[ch] = s[ch];
            if (s[ch] < peak_lo[ch])
                peak_lo[ch] = s[ch];
        end
        if (!w.frame_end)
            return;
        eff_w = (model_weight > dcfps_pkg::WEIGHT_ONE) ? 32'(dcfps_pkg::WEIGHT_ONE)
                                                       : 32'(model_weight);
        for (int ch = 0; ch < 2; ch++)
        begin
            raw = (peak_hi[ch] >= peak_lo[ch]) ? 32'(peak_hi[ch]) - 32'(peak_lo[ch]) : 0;
            acc = eff_w * raw + (32'(dcfps_pkg::WEIGHT_ONE) - eff_w) * 32'(smooth[ch]);
            smooth[ch] = SB'(acc >> dcfps_pkg::FRAC_BITS);
            mid[ch] = SB'((int'(peak_hi[ch]) + int'(peak_lo[ch])) >> 1);
            peak_hi[ch] = '0;
            peak_lo[ch] = SB'(FULL_SCALE);
        end
        stats_due.push_back('{smooth[0], smooth[1], mid[0], mid[1]});
    endtask

    task automatic queue_pair(input int a, input int b, input bit last);
        pair_queue.push_back('{SB'(a), SB'(b), last});
    endtask

    function automatic int pick_sample(input spread_t s, input int center);
        int v;
        case (s)
            SPREAD_FULL:
                v = $urandom_range(0, FULL_SCALE);
            SPREAD_EDGES:
                case ($urandom_range(0, 3))
                    0: v = $urandom_range(0, 7);
                    1: v = FULL_SCALE - int'($urandom_range(0, 7));
                    2: v = $urandom_range(0, 1) ? FULL_SCALE : 0;
                    default: v = $urandom_range(0, FULL_SCALE);
                endcase
            default:
            begin
                v = center + int'($urandom_range(0, 128)) - 64;
                if (v < 0)
                    v = 0;
                if (v > FULL_SCALE)
                    v = FULL_SCALE;
            end
        endcase
        return v;
    endfunction

    task automatic random_phase(input int n_pairs);
        int queued;
        int len;
        int center_a;
        int center_b;
        spread_t spread_a;
        spread_t spread_b;
        queued = 0;
        while (queued < n_pairs)
        begin
            case ($urandom_range(0, 9))
                0, 1: len = 1;
                8: len = $urandom_range(13, 40);
                default: len = $urandom_range(2, 12);
            endcase
            spread_a = spread_t'($urandom_range(0, 2));
            spread_b = spread_t'($urandom_range(0, 2));
            center_a = $urandom_range(0, FULL_SCALE);
            center_b = $urandom_range(0, FULL_SCALE);
            for (int i = 0; i < len; i++)
                queue_pair(pick_sample(spread_a, center_a), pick_sample(spread_b, center_b),
                           i == len - 1);
            queued += len;
        end
    endtask

    task automatic write_weight(input logic [dcfps_pkg::WEIGHT_BITS-1:0] value);
        @(posedge clk);
        weight_bus.valid <= 1'b1;
        weight_bus.filter_weight <= value;
        do
            @(posedge clk);
        while (!weight_bus.ready);
        weight_bus.valid <= 1'b0;
        weight_writes++;
    endtask

    task automatic wait_idle();
        while (pair_queue.size() != 0 || pair_bus.valid || stats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            pair_bus.valid <= 1'b0;
        else if (!pair_bus.valid || pair_bus.ready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                pair_bus.valid <= 1'b0;
            end
            else if (pair_queue.size() != 0)
            begin
                next_pair = pair_queue.pop_front();
                pair_bus.sample_a  <= next_pair.sample_a;
                pair_bus.sample_b  <= next_pair.sample_b;
                pair_bus.frame_end <= next_pair.frame_end;
                pair_bus.valid     <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = sender_steady ? 0 : $urandom_range(0, 7);
                end
            end
            else
                pair_bus.valid <= 1'b0;
        end
    end

    // Receiver: runs of ready separated by stalls, independent of valid.
    always @(posedge clk)
    begin
        if (!rst_n)
            stats_bus.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            stats_bus.ready <= 1'b0;
        end
        else
        begin
            stats_bus.ready <= 1'b1;
            if (run_left > 1)
                run_left--;
            else
            begin
                run_left = $urandom_range(1, 16);
                hold_left = receiver_steady ? 0 : $urandom_range(0, 10);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (weight_bus.valid && weight_bus.ready)
                model_weight = weight_bus.filter_weight;
            if (pair_bus.valid && pair_bus.ready)
            begin
                track_pair('{pair_bus.sample_a, pair_bus.sample_b, pair_bus.frame_end});
                pairs_sent++;
            end
            if (stats_bus.valid && stats_bus.ready)
            begin
                if (stats_due.size() == 0)
                    report_mismatch("result word with no frame pending");
                else
                begin
                    frame_stats_t want;
                    want = stats_due.pop_front();
                    check_field("swing_a", stats_bus.swing_a, want.swing_a);
                    check_field("swing_b", stats_bus.swing_b, want.swing_b);
                    check_field("midpoint_a", stats_bus.midpoint_a, want.midpoint_a);
                    check_field("midpoint_b", stats_bus.midpoint_b, want.midpoint_b);
                end
                frames_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [dcfps_pkg::WEIGHT_BITS-1:0] plan [8];
        rst_n = 1'b0;
        pair_bus.valid = 1'b0;
        pair_bus.sample_a = '0;
        pair_bus.sample_b = '0;
        pair_bus.frame_end = 1'b0;
        stats_bus.ready = 1'b0;
        weight_bus.valid = 1'b0;
        weight_bus.filter_weight = dcfps_pkg::WEIGHT_RESET;
        model_weight = dcfps_pkg::WEIGHT_RESET;
        for (int ch = 0; ch < 2; ch++)
        begin
            peak_hi[ch] = '0;
            peak_lo[ch] = SB'(FULL_SCALE);
            smooth[ch] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // single-word and short multi-word frames, including the extremes
        queue_pair(0, FULL_SCALE, 1);
        queue_pair(FULL_SCALE, 0, 1);
        queue_pair(0, 0, 0);
        queue_pair(FULL_SCALE, FULL_SCALE, 1);
        queue_pair('hAAA, 'h555, 0);
        queue_pair('h555, 'hAAA, 1);
        queue_pair(2048, 1, 0);
        queue_pair(2047, 4094, 0);
        queue_pair(1, 2048, 1);
        queue_pair(FULL_SCALE, FULL_SCALE, 1);
        queue_pair(0, 0, 1);
        queue_pair(5, 4000, 0);
        queue_pair(4000, 5, 0);
        queue_pair(100, 100, 0);
        queue_pair(3000, 3000, 1);
        // back-to-back frame ends
        queue_pair(123, 3210, 1);
        queue_pair(3210, 123, 1);
        queue_pair(0, FULL_SCALE, 1);
        queue_pair(FULL_SCALE, 0, 1);
        random_phase(PAIRS_PER_PHASE);
        wait_idle();

        // zero, unity, above unity (saturates), small, near-unity, random and reset weights
        plan = '{9'd0, dcfps_pkg::WEIGHT_ONE, 9'd511, 9'd1, 9'd255, 9'd257,
                 9'($urandom_range(2, 254)), dcfps_pkg::WEIGHT_RESET};
        for (int p = 0; p < 8; p++)
        begin
            sender_steady = (p % 3 == 1);
            receiver_steady = (p % 4 == 2);
            write_weight(plan[p]);
            random_phase(PAIRS_PER_PHASE);
            wait_idle();
        end

        $display("Ran %0d sample-pair words forming %0d frames", pairs_sent, frames_checked);
        $display("under %0d weight settings; %0d mismatches", weight_writes + 1, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
